/* src/ffba_pkg.sv */
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int HEAP_BYTES   = 1048576;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 8;
    localparam int MAX_BLOCKS   = 64;

    localparam int DATA_W = 20;
    localparam int WANT_W = DATA_W + 1;
    localparam int NEED_W = DATA_W + 2;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

    localparam logic [CFG_W-1:0] MIN_SPLIT_RESET = CFG_W'(16);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESIZE  = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_OUTSIDE  = 3'd2,
        ST_NOTBLOCK = 3'd3,
        ST_DOUBLE   = 3'd4,
        ST_NULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_INS  = 2'd1,
        SH_REM  = 2'd2
    } t_shift;

    typedef enum logic [2:0] {
        CTX_ALLOC  = 3'd0,
        CTX_REL    = 3'd1,
        CTX_RSZREL = 3'd2,
        CTX_RSZ    = 3'd3,
        CTX_RELOC  = 3'd4
    } t_ctx;

    typedef enum logic [4:0] {
        S_IDLE, S_LCHK, S_LSCAN, S_LPICK, S_LWAIT, S_LEVAL,
        S_RLWAIT1, S_RL2, S_RLWAIT2, S_RL3,
        S_RSWAIT1, S_RS2, S_RSWAIT2, S_RS3,
        S_RGWAIT, S_RG2, S_RG3,
        S_ASCAN, S_APICK, S_AWAIT, S_ASPLIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] size;
        logic              free;
    } t_entry;

    typedef struct packed {
        t_shift            mode;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] ins_start;
        logic [DATA_W-1:0] ins_size;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_pos;
        logic [DATA_W-1:0] wr_size;
        logic              wr_free;
    } t_cmd;

    typedef struct packed {
        logic              fit;
        logic [WANT_W-1:0] want;
        logic [DATA_W-1:0] addr;
        logic [CNT_W-1:0]  count;
    } t_key;

    function automatic logic [WANT_W-1:0] round_up(input logic [DATA_W-1:0] n);
        logic [WANT_W-1:0] tmp;
        tmp = {1'b0, n} + WANT_W'(ALIGN_BYTES - 1);
        return WANT_W'((tmp / ALIGN_BYTES) * ALIGN_BYTES);
    endfunction

endpackage

/* src/ffba_cell.sv */
`timescale 1ns / 1ps

module ffba_cell import ffba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_entry           i_left,
    input  t_entry           i_right,
    input  t_cmd             i_cmd,
    input  t_key             i_key,
    output t_entry           o_entry,
    output logic             o_hit
);

    t_entry r_e, n_e;
    logic   r_hit, n_hit;

    always_comb begin
        n_e = r_e;
        unique case (i_cmd.mode)
            SH_INS: begin
                if (i_idx > i_cmd.pos) begin
                    n_e = i_left;
                end else if (i_idx == i_cmd.pos) begin
                    n_e.start = i_cmd.ins_start;
                    n_e.size  = i_cmd.ins_size;
                    n_e.free  = 1'b1;
                end
            end
            SH_REM: begin
                if (i_idx >= i_cmd.pos) begin
                    n_e = i_right;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.wr_en && (i_idx == i_cmd.wr_pos)) begin
            n_e.size = i_cmd.wr_size;
            n_e.free = i_cmd.wr_free;
        end
    end

    always_comb begin
        n_hit = 1'b0;
        if ({1'b0, i_idx} < i_key.count) begin
            if (i_key.fit) begin
                n_hit = r_e.free && ({1'b0, r_e.size} >= i_key.want);
            end else begin
                n_hit = (({1'b0, r_e.start} + WANT_W'(HEADER_BYTES)) == {1'b0, i_key.addr});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.start <= '0;
            r_e.size  <= DATA_W'(HEAP_BYTES - HEADER_BYTES);
            r_e.free  <= 1'b1;
            r_hit     <= 1'b0;
        end else begin
            r_e   <= n_e;
            r_hit <= n_hit;
        end
    end

    assign o_entry = r_e;
    assign o_hit   = r_hit;

endmodule

/* src/ffba_ctrl.sv */
`timescale 1ns / 1ps

module ffba_ctrl import ffba_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_operation,
    input  logic [DATA_W-1:0]          i_request_bytes,
    input  logic                       i_address_is_null,
    input  logic [DATA_W-1:0]          i_address,
    output logic                       o_done,
    output logic [2:0]                 o_status,
    output logic [DATA_W-1:0]          o_result_address,
    output logic [DATA_W-1:0]          o_granted_bytes,
    output logic                       o_moved,
    output logic [DATA_W-1:0]          o_copy_bytes,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_W-1:0]           i_cfg_min_split_bytes,
    input  t_entry [MAX_BLOCKS-1:0]    i_ents,
    input  logic [MAX_BLOCKS-1:0]      i_hits,
    output t_cmd                       o_cmd,
    output t_key                       o_key
);

    t_state r_state, n_state;
    t_ctx   r_ctx, n_ctx;
    logic [CFG_W-1:0]  r_min;
    logic [WANT_W-1:0] r_want, n_want;
    logic [DATA_W-1:0] r_req, n_req;
    logic [DATA_W-1:0] r_laddr, n_laddr;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_fit, n_fit;
    t_entry            r_rd;
    t_entry            r_cur, n_cur;
    logic [DATA_W-1:0] r_e1, n_e1;
    logic [DATA_W-1:0] r_sz, n_sz;
    logic [DATA_W-1:0] r_old_start, n_old_start;
    logic [DATA_W-1:0] r_old_size, n_old_size;
    t_status           r_st, n_st;
    logic [DATA_W-1:0] r_raddr, n_raddr;
    logic [DATA_W-1:0] r_gsz, n_gsz;
    logic              r_moved, n_moved;
    logic [DATA_W-1:0] r_copy, n_copy;

    logic [MAX_BLOCKS-1:0] hit_lsb;
    logic [IDX_W-1:0]      pick_idx;
    logic                  found;
    logic [CNT_W-1:0]      ip1, ip2;
    logic                  ip1_ok, ip2_ok;
    logic [DATA_W-1:0]     sp_start, sp_size;
    logic [NEED_W-1:0]     sp_need;
    logic                  sp_split;
    logic [DATA_W-1:0]     sp_ins_start, sp_ins_size, sp_gsz;
    logic [WANT_W-1:0]     sum_next, sum_prev, sum_e1;
    logic                  rd_fits, grow_ok, addr_out, addr_low, req_zero;
    t_op                   op_in;

    // First-fit pick over the registered hit flags of the cells.
    always_comb begin
        hit_lsb  = i_hits & (~i_hits + 1'b1);
        pick_idx = '0;
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (hit_lsb[k]) begin
                pick_idx = pick_idx | IDX_W'(k);
            end
        end
        found = |i_hits;
    end

    always_comb begin
        op_in    = t_op'(i_operation);
        req_zero = (i_request_bytes == '0);
        ip1      = {1'b0, r_idx} + CNT_W'(1);
        ip2      = {1'b0, r_idx} + CNT_W'(2);
        ip1_ok   = ip1 < r_cnt;
        ip2_ok   = ip2 < r_cnt;
        addr_out = (32'(r_laddr) >= 32'(HEAP_BYTES));
        addr_low = (32'(r_laddr) < 32'(HEADER_BYTES));
        if (r_state == S_RG3) begin
            sp_start = r_cur.start;
            sp_size  = r_sz;
        end else begin
            sp_start = r_rd.start;
            sp_size  = r_rd.size;
        end
        sp_need  = NEED_W'(r_want) + NEED_W'(HEADER_BYTES) + NEED_W'(r_min);
        sp_split = (r_cnt < CNT_W'(MAX_BLOCKS)) && ({2'b0, sp_size} >= sp_need);
        sp_ins_start = DATA_W'({1'b0, sp_start} + WANT_W'(HEADER_BYTES) + r_want);
        sp_ins_size  = DATA_W'({1'b0, sp_size} - r_want - WANT_W'(HEADER_BYTES));
        sp_gsz   = sp_split ? DATA_W'(r_want) : sp_size;
        sum_next = {1'b0, r_cur.size} + WANT_W'(HEADER_BYTES) + {1'b0, r_rd.size};
        sum_prev = {1'b0, r_rd.size} + WANT_W'(HEADER_BYTES) + {1'b0, r_sz};
        sum_e1   = {1'b0, r_e1} + WANT_W'(HEADER_BYTES) + {1'b0, r_rd.size};
        rd_fits  = {1'b0, r_rd.size} >= r_want;
        grow_ok  = ip1_ok && r_rd.free && (sum_next >= r_want);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (op_in)
                        OP_ALLOC: n_state = req_zero ? S_DONE : S_ASCAN;
                        OP_RELEASE: n_state = i_address_is_null ? S_DONE : S_LCHK;
                        OP_RESIZE: begin
                            if (i_address_is_null) begin
                                n_state = req_zero ? S_DONE : S_ASCAN;
                            end else begin
                                n_state = S_LCHK;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_LCHK:    n_state = (addr_out || addr_low) ? S_DONE : S_LSCAN;
            S_LSCAN:   n_state = S_LPICK;
            S_LPICK:   n_state = found ? S_LWAIT : S_DONE;
            S_LWAIT:   n_state = S_LEVAL;
            S_LEVAL: begin
                if (r_rd.free) begin
                    n_state = S_DONE;
                end else if (r_ctx == CTX_RSZ) begin
                    n_state = rd_fits ? S_RSWAIT1 : S_RGWAIT;
                end else begin
                    n_state = S_RLWAIT1;
                end
            end
            S_RLWAIT1: n_state = S_RL2;
            S_RL2:     n_state = S_RLWAIT2;
            S_RLWAIT2: n_state = S_RL3;
            S_RL3:     n_state = S_DONE;
            S_RSWAIT1: n_state = S_RS2;
            S_RS2:     n_state = (ip1_ok && r_rd.free) ? S_RSWAIT2 : S_DONE;
            S_RSWAIT2: n_state = S_RS3;
            S_RS3:     n_state = S_DONE;
            S_RGWAIT:  n_state = S_RG2;
            S_RG2:     n_state = grow_ok ? S_RG3 : S_ASCAN;
            S_RG3:     n_state = S_DONE;
            S_ASCAN:   n_state = S_APICK;
            S_APICK:   n_state = found ? S_AWAIT : S_DONE;
            S_AWAIT:   n_state = S_ASPLIT;
            S_ASPLIT:  n_state = (r_ctx == CTX_RELOC) ? S_LCHK : S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath updates and cell commands.
    always_comb begin
        n_ctx = r_ctx;       n_want = r_want;     n_req = r_req;
        n_laddr = r_laddr;   n_idx = r_idx;       n_ptr = r_ptr;
        n_cnt = r_cnt;       n_fit = r_fit;       n_cur = r_cur;
        n_e1 = r_e1;         n_sz = r_sz;
        n_old_start = r_old_start;                n_old_size = r_old_size;
        n_st = r_st;         n_raddr = r_raddr;   n_gsz = r_gsz;
        n_moved = r_moved;   n_copy = r_copy;
        o_cmd = '0;
        o_cmd.mode = SH_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_st = ST_OK; n_raddr = '0; n_gsz = '0; n_moved = 1'b0; n_copy = '0;
                    n_want  = round_up(i_request_bytes);
                    n_req   = i_request_bytes;
                    n_laddr = i_address;
                    n_fit   = 1'b0;
                    unique case (op_in)
                        OP_ALLOC: begin
                            n_ctx = CTX_ALLOC;
                            n_fit = 1'b1;
                            if (req_zero) n_st = ST_NULL;
                        end
                        OP_RELEASE: n_ctx = CTX_REL;
                        OP_RESIZE: begin
                            if (i_address_is_null) begin
                                n_ctx = CTX_ALLOC;
                                n_fit = 1'b1;
                                if (req_zero) n_st = ST_NULL;
                            end else begin
                                n_ctx = req_zero ? CTX_RSZREL : CTX_RSZ;
                            end
                        end
                        default: n_ctx = CTX_ALLOC;
                    endcase
                end
            end
            S_LCHK: begin
                n_fit = 1'b0;
                if (addr_out) begin
                    n_st = ST_OUTSIDE;
                end else if (addr_low) begin
                    n_st = ST_NOTBLOCK;
                end
            end
            S_LPICK: begin
                n_idx = pick_idx;
                n_ptr = pick_idx;
                if (!found) n_st = ST_NOTBLOCK;
            end
            S_LEVAL: begin
                n_cur = r_rd;
                n_ptr = IDX_W'(ip1);
                if (r_rd.free) begin
                    n_st = ST_DOUBLE;
                end else if ((r_ctx == CTX_RSZ) && rd_fits) begin
                    // Shrink in place, splitting off the tail when it is large enough and the table has room.
                    if (sp_split) begin
                        o_cmd.mode      = SH_INS;
                        o_cmd.pos       = IDX_W'(ip1);
                        o_cmd.ins_start = sp_ins_start;
                        o_cmd.ins_size  = sp_ins_size;
                        n_cnt           = r_cnt + CNT_W'(1);
                    end
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_pos  = r_idx;
                    o_cmd.wr_size = sp_gsz;
                    o_cmd.wr_free = 1'b0;
                    n_st    = ST_OK;
                    n_raddr = r_laddr;
                    n_gsz   = sp_gsz;
                end
            end
            S_RL2: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_pos  = r_idx;
                o_cmd.wr_free = 1'b1;
                if (ip1_ok && r_rd.free) begin
                    o_cmd.mode    = SH_REM;
                    o_cmd.pos     = IDX_W'(ip1);
                    o_cmd.wr_size = DATA_W'(sum_next);
                    n_sz          = DATA_W'(sum_next);
                    n_cnt         = r_cnt - CNT_W'(1);
                end else begin
                    o_cmd.wr_size = r_cur.size;
                    n_sz          = r_cur.size;
                end
                n_ptr = r_idx - IDX_W'(1);
            end
            S_RL3: begin
                if ((r_idx != '0) && r_rd.free) begin
                    o_cmd.mode    = SH_REM;
                    o_cmd.pos     = r_idx;
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_pos  = r_idx - IDX_W'(1);
                    o_cmd.wr_size = DATA_W'(sum_prev);
                    o_cmd.wr_free = 1'b1;
                    n_cnt         = r_cnt - CNT_W'(1);
                end
                if (r_ctx == CTX_RSZREL) begin
                    n_st = ST_NULL;
                end else if (r_ctx != CTX_RELOC) begin
                    n_st = ST_OK;
                end
            end
            S_RS2: begin
                n_e1  = r_rd.size;
                n_ptr = IDX_W'(ip2);
            end
            S_RS3: begin
                if (ip2_ok && r_rd.free) begin
                    o_cmd.mode    = SH_REM;
                    o_cmd.pos     = IDX_W'(ip2);
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_pos  = IDX_W'(ip1);
                    o_cmd.wr_size = DATA_W'(sum_e1);
                    o_cmd.wr_free = 1'b1;
                    n_cnt         = r_cnt - CNT_W'(1);
                end
            end
            S_RG2: begin
                if (grow_ok) begin
                    o_cmd.mode    = SH_REM;
                    o_cmd.pos     = IDX_W'(ip1);
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_pos  = r_idx;
                    o_cmd.wr_size = DATA_W'(sum_next);
                    o_cmd.wr_free = 1'b0;
                    n_sz          = DATA_W'(sum_next);
                    n_cnt         = r_cnt - CNT_W'(1);
                end else begin
                    n_old_start = r_cur.start;
                    n_old_size  = r_cur.size;
                    n_ctx       = CTX_RELOC;
                    n_fit       = 1'b1;
                end
            end
            S_RG3: begin
                if (sp_split) begin
                    o_cmd.mode      = SH_INS;
                    o_cmd.pos       = IDX_W'(ip1);
                    o_cmd.ins_start = sp_ins_start;
                    o_cmd.ins_size  = sp_ins_size;
                    n_cnt           = r_cnt + CNT_W'(1);
                end
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_pos  = r_idx;
                o_cmd.wr_size = sp_gsz;
                o_cmd.wr_free = 1'b0;
                n_st    = ST_OK;
                n_raddr = r_laddr;
                n_gsz   = sp_gsz;
            end
            S_APICK: begin
                n_idx = pick_idx;
                n_ptr = pick_idx;
                if (!found) n_st = ST_NOSPACE;
            end
            S_ASPLIT: begin
                if (sp_split) begin
                    o_cmd.mode      = SH_INS;
                    o_cmd.pos       = IDX_W'(ip1);
                    o_cmd.ins_start = sp_ins_start;
                    o_cmd.ins_size  = sp_ins_size;
                    n_cnt           = r_cnt + CNT_W'(1);
                end
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_pos  = r_idx;
                o_cmd.wr_size = sp_gsz;
                o_cmd.wr_free = 1'b0;
                n_st    = ST_OK;
                n_raddr = DATA_W'({1'b0, r_rd.start} + WANT_W'(HEADER_BYTES));
                n_gsz   = sp_gsz;
                if (r_ctx == CTX_RELOC) begin
                    n_moved = 1'b1;
                    n_copy  = (r_old_size < r_req) ? r_old_size : r_req;
                    n_laddr = DATA_W'({1'b0, r_old_start} + WANT_W'(HEADER_BYTES));
                    n_fit   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctx   <= CTX_ALLOC;
            r_cnt   <= CNT_W'(1);
            r_min   <= MIN_SPLIT_RESET;
            r_fit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ctx   <= n_ctx;
            r_cnt   <= n_cnt;
            r_fit   <= n_fit;
            if (i_cfg_valid) r_min <= i_cfg_min_split_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        r_want <= n_want;   r_req <= n_req;     r_laddr <= n_laddr;
        r_idx <= n_idx;     r_ptr <= n_ptr;     r_cur <= n_cur;
        r_e1 <= n_e1;       r_sz <= n_sz;
        r_old_start <= n_old_start;             r_old_size <= n_old_size;
        r_st <= n_st;       r_raddr <= n_raddr; r_gsz <= n_gsz;
        r_moved <= n_moved; r_copy <= n_copy;
        r_rd <= i_ents[r_ptr];
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = (r_state == S_DONE);
    assign o_status         = r_st;
    assign o_result_address = r_raddr;
    assign o_granted_bytes  = r_gsz;
    assign o_moved          = r_moved;
    assign o_copy_bytes     = r_copy;
    assign o_cfg_ready      = 1'b1;

    assign o_key.fit   = r_fit;
    assign o_key.want  = r_want;
    assign o_key.addr  = r_laddr;
    assign o_key.count = r_cnt;

endmodule

/* src/first_fit_block_allocator_unit.sv */
`timescale 1ns / 1ps

// Channel | Dir | Handshake     | Payload
// --------+-----+---------------+-------------------------------------------------------------
// request | in  | start & !busy | i_operation i_request_bytes i_address_is_null i_address
// result  | out | o_done strobe | o_status o_result_address o_granted_bytes o_moved o_copy_bytes
// config  | in  | valid & ready | i_cfg_min_split_bytes (i_cfg_valid, o_cfg_ready)
//
// One item is worked on at a time. How long an item runs is set by the sequencer's scan, pick
// and neighbor read steps over the row of cells; a trivial item (null, zero size or no
// operation) skips them, and a rejected address ends the item after the address check,
// the search or the read of its entry.
// Reset is synchronous and active low; it leaves one free block covering the heap.
// No clearing pass is needed. The result strobe cannot be stalled by the receiver.

module first_fit_block_allocator_unit import ffba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_operation,
    input  logic [DATA_W-1:0] i_request_bytes,
    input  logic              i_address_is_null,
    input  logic [DATA_W-1:0] i_address,
    output logic              o_done,
    output logic [2:0]        o_status,
    output logic [DATA_W-1:0] o_result_address,
    output logic [DATA_W-1:0] o_granted_bytes,
    output logic              o_moved,
    output logic [DATA_W-1:0] o_copy_bytes,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_min_split_bytes
);

    // The block table lives in a row of cells in address order. Each cell keeps one
    // entry and takes its left neighbor's entry on an insert or its right neighbor's
    // entry on a removal, so a split or a merge shifts all entries behind that point together.
    t_entry [MAX_BLOCKS-1:0] ents;
    logic   [MAX_BLOCKS-1:0] hits;
    t_cmd                    cmd;
    t_key                    key;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        t_entry left_e, right_e;
        // The end cells see themselves as neighbors; the first cell never selects its left path.
        if (g == 0) begin : g_first
            assign left_e = ents[g];
        end else begin : g_mid_l
            assign left_e = ents[g-1];
        end
        if (g == MAX_BLOCKS - 1) begin : g_last
            assign right_e = ents[g];
        end else begin : g_mid_r
            assign right_e = ents[g+1];
        end
        ffba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_left  (left_e),
            .i_right (right_e),
            .i_cmd   (cmd),
            .i_key   (key),
            .o_entry (ents[g]),
            .o_hit   (hits[g])
        );
    end

    // The sequencer broadcasts search keys to all cells, picks the first hit, reads
    // neighbors one at a time and issues insert, remove and write commands.
    ffba_ctrl u_ctrl (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_operation           (i_operation),
        .i_request_bytes       (i_request_bytes),
        .i_address_is_null     (i_address_is_null),
        .i_address             (i_address),
        .o_done                (o_done),
        .o_status              (o_status),
        .o_result_address      (o_result_address),
        .o_granted_bytes       (o_granted_bytes),
        .o_moved               (o_moved),
        .o_copy_bytes          (o_copy_bytes),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_min_split_bytes (i_cfg_min_split_bytes),
        .i_ents                (ents),
        .i_hits                (hits),
        .o_cmd                 (cmd),
        .o_key                 (key)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block still busy after delivering a result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |->
            ((o_result_address == '0) && (o_granted_bytes == '0) && !o_moved))
        else $error("failed item carries a granted area");

    a_moved_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_moved) |-> (o_copy_bytes == '0))
        else $error("copy length given without relocation");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ffba_pkg::*;

    // Request item fields, as they are driven onto the request ports.
    typedef struct {
        logic [1:0]        op;
        logic [DATA_W-1:0] req_bytes;
        logic              is_null;
        logic [DATA_W-1:0] addr;
    } t_request;

    // Result item fields, as they appear on the result ports.
    typedef struct {
        logic [2:0]        status;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] granted;
        logic              moved;
        logic [DATA_W-1:0] copy;
    } t_grant;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_operation;
    logic [DATA_W-1:0] i_request_bytes;
    logic              i_address_is_null;
    logic [DATA_W-1:0] i_address;
    logic              o_done;
    logic [2:0]        o_status;
    logic [DATA_W-1:0] o_result_address;
    logic [DATA_W-1:0] o_granted_bytes;
    logic              o_moved;
    logic [DATA_W-1:0] o_copy_bytes;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_min_split_bytes;

    first_fit_block_allocator_unit u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_operation           (i_operation),
        .i_request_bytes       (i_request_bytes),
        .i_address_is_null     (i_address_is_null),
        .i_address             (i_address),
        .o_done                (o_done),
        .o_status              (o_status),
        .o_result_address      (o_result_address),
        .o_granted_bytes       (o_granted_bytes),
        .o_moved               (o_moved),
        .o_copy_bytes          (o_copy_bytes),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_min_split_bytes (i_cfg_min_split_bytes)
    );

    localparam int CYCLE_LIMIT = 400000;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Shadow copy of the block table and the split threshold. Sizes and
    // starts are held 32 bits wide so that the arithmetic does not wrap.
    int unsigned shadow_start[MAX_BLOCKS];
    int unsigned shadow_size[MAX_BLOCKS];
    bit          shadow_free[MAX_BLOCKS];
    int unsigned shadow_count;
    int unsigned split_min;

    t_request pending_requests[$];
    t_grant   expected_grants[$];
    int       live_addrs[$];      // data offsets believed allocated
    int       freed_addrs[$];     // data offsets that were released
    bit       failed;
    bit       quiet_driver;       // set for the stretch with no idling
    int       cycle_count;

    function automatic int unsigned align_up(int unsigned n);
        return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic void drop_entry(int unsigned i);
        for (int unsigned k = i; k + 1 < shadow_count; k++) begin
            shadow_start[k] = shadow_start[k+1];
            shadow_size[k]  = shadow_size[k+1];
            shadow_free[k]  = shadow_free[k+1];
        end
        shadow_count--;
    endfunction

    function automatic void carve(int unsigned i, int unsigned want);
        if (shadow_count >= MAX_BLOCKS || shadow_size[i] < want + HEADER_BYTES + split_min)
            return;
        for (int unsigned k = shadow_count; k > i + 1; k--) begin
            shadow_start[k] = shadow_start[k-1];
            shadow_size[k]  = shadow_size[k-1];
            shadow_free[k]  = shadow_free[k-1];
        end
        shadow_start[i+1] = shadow_start[i] + HEADER_BYTES + want;
        shadow_size[i+1]  = shadow_size[i] - want - HEADER_BYTES;
        shadow_free[i+1]  = 1'b1;
        shadow_size[i]    = want;
        shadow_count++;
    endfunction

    function automatic void absorb_next(int unsigned i);
        if (i + 1 < shadow_count && shadow_free[i+1]) begin
            shadow_size[i] += HEADER_BYTES + shadow_size[i+1];
            drop_entry(i + 1);
        end
    endfunction

    function automatic int first_fit(int unsigned n);
        int unsigned want;
        want = align_up(n);
        for (int unsigned i = 0; i < shadow_count; i++) begin
            if (shadow_free[i] && shadow_size[i] >= want) begin
                carve(i, want);
                shadow_free[i] = 1'b0;
                return int'(i);
            end
        end
        return -1;
    endfunction

    function automatic t_status find_block(int unsigned addr, output int unsigned idx);
        idx = 0;
        if (addr >= HEAP_BYTES) return ST_OUTSIDE;
        if (addr < HEADER_BYTES) return ST_NOTBLOCK;
        for (int unsigned i = 0; i < shadow_count; i++) begin
            if (shadow_start[i] + HEADER_BYTES == addr) begin
                idx = i;
                return shadow_free[i] ? ST_DOUBLE : ST_OK;
            end
        end
        return ST_NOTBLOCK;
    endfunction

    function automatic t_status free_block(int unsigned addr);
        int unsigned idx;
        t_status     st;
        st = find_block(addr, idx);
        if (st != ST_OK) return st;
        shadow_free[idx] = 1'b1;
        absorb_next(idx);
        if (idx > 0 && shadow_free[idx-1]) absorb_next(idx - 1);
        return ST_OK;
    endfunction

    function automatic t_grant make_grant(t_status st, int unsigned a, int unsigned g,
                                          bit mv, int unsigned c);
        t_grant r;
        r.status  = st;
        r.addr    = a[DATA_W-1:0];
        r.granted = g[DATA_W-1:0];
        r.moved   = mv;
        r.copy    = c[DATA_W-1:0];
        return r;
    endfunction

    function automatic t_grant grant_alloc(int unsigned n);
        int j;
        if (n == 0) return make_grant(ST_NULL, 0, 0, 0, 0);
        j = first_fit(n);
        if (j < 0) return make_grant(ST_NOSPACE, 0, 0, 0, 0);
        return make_grant(ST_OK, shadow_start[j] + HEADER_BYTES, shadow_size[j], 0, 0);
    endfunction

    // Computes the result of one request and advances the shadow table.
    function automatic t_grant predict_grant(t_request rq);
        int unsigned req, addr, idx, want, old_start, old_size;
        t_status     st;
        int          j;
        t_grant      r;
        req  = rq.req_bytes;
        addr = rq.addr;
        case (rq.op)
            OP_ALLOC:   return grant_alloc(req);
            OP_RELEASE: return make_grant(rq.is_null ? ST_OK : free_block(addr), 0, 0, 0, 0);
            OP_NONE:    return make_grant(ST_OK, 0, 0, 0, 0);
            default:    ;
        endcase
        if (rq.is_null) return grant_alloc(req);
        if (req == 0) begin
            st = free_block(addr);
            return make_grant(st == ST_OK ? ST_NULL : st, 0, 0, 0, 0);
        end
        st = find_block(addr, idx);
        if (st != ST_OK) return make_grant(st, 0, 0, 0, 0);
        want = align_up(req);
        if (shadow_size[idx] >= want) begin
            // Shrink in place; the cut-off tail joins a free successor.
            carve(idx, want);
            if (idx + 1 < shadow_count && shadow_free[idx+1]) absorb_next(idx + 1);
            return make_grant(ST_OK, addr, shadow_size[idx], 0, 0);
        end
        if (idx + 1 < shadow_count && shadow_free[idx+1] &&
            shadow_size[idx] + HEADER_BYTES + shadow_size[idx+1] >= want) begin
            absorb_next(idx);
            carve(idx, want);
            return make_grant(ST_OK, addr, shadow_size[idx], 0, 0);
        end
        old_start = shadow_start[idx];
        old_size  = shadow_size[idx];
        j = first_fit(req);
        if (j < 0) return make_grant(ST_NOSPACE, 0, 0, 0, 0);
        r = make_grant(ST_OK, shadow_start[j] + HEADER_BYTES, shadow_size[j], 1,
                       old_size < req ? old_size : req);
        void'(free_block(old_start + HEADER_BYTES));
        return r;
    endfunction

    // Driver: presents a queued request at the falling edge only while the block
    // is idle, so the item is always taken at the next rising edge and start is
    // dropped at the falling edge after it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!busy && pending_requests.size() > 0 &&
                     (quiet_driver || $urandom_range(99) >= 13)) begin
            t_request rq;
            rq = pending_requests.pop_front();
            start             <= 1'b1;
            i_operation       <= rq.op;
            i_request_bytes   <= rq.req_bytes;
            i_address_is_null <= rq.is_null;
            i_address         <= rq.addr;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: predicts at acceptance and checks each strobed result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (start && !busy) begin
                t_request rq;
                t_grant   g;
                rq.op        = i_operation;
                rq.req_bytes = i_request_bytes;
                rq.is_null   = i_address_is_null;
                rq.addr      = i_address;
                g = predict_grant(rq);
                expected_grants.push_back(g);
                if (g.status == ST_OK && (rq.op == OP_ALLOC || rq.op == OP_RESIZE)
                    && g.granted != 0)
                    live_addrs.push_back(g.addr);
            end
            if (o_done) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected result status %0d", $time, o_status);
                    failed <= 1'b1;
                end else begin
                    t_grant e;
                    e = expected_grants.pop_front();
                    if (e.status !== o_status || e.addr !== o_result_address ||
                        e.granted !== o_granted_bytes || e.moved !== o_moved ||
                        e.copy !== o_copy_bytes) begin
                        $display("%0t: mismatch expected st=%0d a=%h g=%h m=%0d c=%h",
                                 $time, e.status, e.addr, e.granted, e.moved, e.copy);
                        $display("%0t:          actual   st=%0d a=%h g=%h m=%0d c=%h",
                                 $time, o_status, o_result_address, o_granted_bytes,
                                 o_moved, o_copy_bytes);
                        failed <= 1'b1;
                    end
                end
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("first_fit_block_allocator_unit test failed");
                $finish;
            end
        end
    end

    function automatic t_request mk_req(t_op op, int unsigned n, bit nul, int unsigned a);
        t_request rq;
        rq.op        = op;
        rq.req_bytes = n[DATA_W-1:0];
        rq.is_null   = nul;
        rq.addr      = a[DATA_W-1:0];
        return rq;
    endfunction

    // Mostly small sizes, now and then a big one or a full-width value.
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 256);
        if (r < 90) return $urandom_range(257, 8192);
        if (r < 97) return $urandom_range(8193, 200000);
        return $urandom_range(0, (1 << DATA_W) - 1);
    endfunction

    // Picks an address: mostly a live allocation, else something broken.
    function automatic int unsigned pick_addr();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75 && live_addrs.size() > 0)
            return live_addrs[$urandom_range(live_addrs.size() - 1)];
        if (r < 85 && freed_addrs.size() > 0)
            return freed_addrs[$urandom_range(freed_addrs.size() - 1)];
        if (r < 92) return $urandom_range(0, HEADER_BYTES - 1);
        return $urandom_range(0, (1 << DATA_W) - 1);
    endfunction

    task automatic wait_idle();
        while (pending_requests.size() > 0 || expected_grants.size() > 0 || start)
            @(posedge i_clk);
        // Every item ends with a result strobe; the extra wait only adds margin.
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_split_min(int unsigned v);
        @(negedge i_clk);
        i_cfg_valid           <= 1'b1;
        i_cfg_min_split_bytes <= v[CFG_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        split_min = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int count);
        int unsigned r, a;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                pending_requests.push_back(mk_req(OP_ALLOC, pick_size(), $urandom_range(1), 0));
            end else if (r < 70) begin
                int k;
                if (live_addrs.size() > 0 && $urandom_range(9) < 8) begin
                    k = $urandom_range(live_addrs.size() - 1);
                    a = live_addrs[k];
                    live_addrs.delete(k);
                    freed_addrs.push_back(a);
                end else begin
                    a = pick_addr();
                end
                pending_requests.push_back(mk_req(OP_RELEASE, 0, $urandom_range(19) == 0, a));
            end else if (r < 97) begin
                a = pick_addr();
                pending_requests.push_back(mk_req(OP_RESIZE,
                    $urandom_range(15) == 0 ? 0 : pick_size(), $urandom_range(15) == 0, a));
            end else begin
                pending_requests.push_back(mk_req(OP_NONE, $urandom, $urandom_range(1),
                                                  $urandom));
            end
            // Let the monitor track addresses handed out before choosing more.
            if (pending_requests.size() > 4)
                while (pending_requests.size() > 1) @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned split_settings[4];
        failed       = 1'b0;
        quiet_driver = 1'b0;
        cycle_count  = 0;
        shadow_count    = 1;
        shadow_start[0] = 0;
        shadow_size[0]  = HEAP_BYTES - HEADER_BYTES;
        shadow_free[0]  = 1'b1;
        split_min       = 16;
        i_rst_n               = 1'b0;
        start                 = 1'b0;
        i_operation           = OP_ALLOC;
        i_request_bytes       = '0;
        i_address_is_null     = 1'b0;
        i_address             = '0;
        i_cfg_valid           = 1'b0;
        i_cfg_min_split_bytes = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: special cases and field extremes.
        pending_requests.push_back(mk_req(OP_ALLOC, 0, 0, 0));
        pending_requests.push_back(mk_req(OP_ALLOC, 1, 0, 0));               // at 32
        pending_requests.push_back(mk_req(OP_ALLOC, 100, 0, 0));             // at 72
        pending_requests.push_back(mk_req(OP_ALLOC, 24, 0, 0));              // at 208
        pending_requests.push_back(mk_req(OP_RELEASE, 0, 1, 0));
        pending_requests.push_back(mk_req(OP_RELEASE, 0, 0, 20'hFFFFF));
        pending_requests.push_back(mk_req(OP_RELEASE, 0, 0, 16));
        pending_requests.push_back(mk_req(OP_RELEASE, 0, 0, 33));
        pending_requests.push_back(mk_req(OP_RELEASE, 0, 0, 72));
        pending_requests.push_back(mk_req(OP_RELEASE, 0, 0, 72));            // double free
        pending_requests.push_back(mk_req(OP_RESIZE, 8, 0, 72));             // free block
        pending_requests.push_back(mk_req(OP_RESIZE, 200, 0, 32));           // too big to grow into next, moves
        pending_requests.push_back(mk_req(OP_RESIZE, 8, 0, 32));             // block freed by the move: double free
        pending_requests.push_back(mk_req(OP_RESIZE, 5000, 0, 208));         // grow or move
        pending_requests.push_back(mk_req(OP_RESIZE, 64, 1, 0));             // null acts as alloc
        pending_requests.push_back(mk_req(OP_RESIZE, 900000, 0, 32));        // relocation succeeds
        pending_requests.push_back(mk_req(OP_RESIZE, 0, 0, 32));             // zero acts as free
        pending_requests.push_back(mk_req(OP_RESIZE, 0, 0, 32));
        pending_requests.push_back(mk_req(OP_ALLOC, 20'hFFFFF, 0, 0));
        pending_requests.push_back(mk_req(OP_NONE, 20'hFFFFF, 1, 20'hFFFFF));
        pending_requests.push_back(mk_req(OP_ALLOC, HEAP_BYTES - HEADER_BYTES, 0, 0));
        pending_requests.push_back(mk_req(OP_RELEASE, 0, 0, 32));
        wait_idle();

        // Random phases, one per split threshold, with the largest value of the field among them.
        split_settings = '{1024, 8, 2047, 16};
        foreach (split_settings[p]) begin
            write_split_min(split_settings[p]);
            quiet_driver = (p == 2);
            // Fill the table with small allocations once to reach the full-table case.
            if (p == 1)
                for (int k = 0; k < 70; k++)
                    pending_requests.push_back(mk_req(OP_ALLOC, $urandom_range(1, 64), 0, 0));
            queue_random(190);
            wait_idle();
        end

        if (!failed) begin
            $display("first_fit_block_allocator_unit test passed");
        end else begin
            $display("first_fit_block_allocator_unit test failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
src/ffba_pkg.sv
src/ffba_cell.sv
src/ffba_ctrl.sv
src/first_fit_block_allocator_unit.sv
verif/tb.sv
